// ----- rtl/core/sfr_pkg.sv -----
package sfr_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] reg_index_type;

   localparam byte_type NEWLINE = 8'd10;

   // request kind carried in tuser
   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // configuration register indexes
   localparam reg_index_type REG_PATTERN_BYTES      = 2'd0;
   localparam reg_index_type REG_PATTERN_LENGTH     = 2'd1;
   localparam reg_index_type REG_REPLACEMENT_BYTES  = 2'd2;
   localparam reg_index_type REG_REPLACEMENT_LENGTH = 2'd3;

endpackage

// ----- rtl/core/sfr_match.sv -----
module sfr_match #(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8,
   localparam int BUF_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
   localparam int COUNT_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
   localparam int EMIT_W    = $clog2(BUF_BYTES + 1)
) (
   input  logic [8*MAX_PATTERN-1:0]     pattern_bytes,
   input  logic [3:0]                   pattern_length,
   input  logic [8*MAX_REPLACEMENT-1:0] replacement_bytes,
   input  logic [3:0]                   replacement_length,
   input  logic [COUNT_W-1:0]           match_count,
   input  logic                         command,
   input  sfr_pkg::byte_type            text_byte,
   output logic [8*BUF_BYTES-1:0]       seq_bytes,
   output logic [EMIT_W-1:0]            emit_count,
   output logic [COUNT_W-1:0]           next_count
);
   import sfr_pkg::*;

   byte_type                 pat [MAX_PATTERN];
   logic [8*BUF_BYTES-1:0]   pat_wide;
   logic [8*BUF_BYTES-1:0]   rep_wide;
   logic [3:0]               eff_len;
   logic [3:0]               eff_rep;
   logic [COUNT_W-1:0]       fallback [MAX_PATTERN];
   logic [EMIT_W-1:0]        held;

   assign pat_wide = (8*BUF_BYTES)'(pattern_bytes);
   assign rep_wide = (8*BUF_BYTES)'(replacement_bytes);
   assign eff_len  = (pattern_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : pattern_length;
   assign eff_rep  = (replacement_length > 4'(MAX_REPLACEMENT)) ?
                     4'(MAX_REPLACEMENT) : replacement_length;
   assign held     = EMIT_W'(match_count);

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat[i] = pattern_bytes[8*i +: 8];
      end
   end

   // Longest tail of (held prefix, new byte) that is again a pattern prefix,
   // worked out for every possible held length; the held bytes are pattern bytes.
   always_comb begin
      logic hit;
      hit = 1'b0;
      for (int kk = 0; kk < MAX_PATTERN; kk++) begin
         fallback[kk] = '0;
         for (int j = 1; j <= kk; j++) begin
            hit = (text_byte == pat[j-1]);
            for (int i = 0; i < j - 1; i++) begin
               hit = hit && (pat[kk+1-j+i] == pat[i]);
            end
            if (hit) begin
               fallback[kk] = COUNT_W'(j);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < BUF_BYTES; i++) begin
         seq_bytes[8*i +: 8] = (i < int'(match_count)) ? pat_wide[8*i +: 8] : text_byte;
      end
      emit_count = '0;
      next_count = '0;
      if (command == CMD_END) begin
         emit_count = held;
      end else if ((4'(match_count) >= eff_len) || (text_byte == NEWLINE)) begin
         emit_count = held + EMIT_W'(1);
      end else if (text_byte == pat[match_count]) begin
         if (4'(match_count) + 4'd1 == eff_len) begin
            seq_bytes  = rep_wide;
            emit_count = EMIT_W'(eff_rep);
         end else begin
            next_count = COUNT_W'(match_count + COUNT_W'(1));
         end
      end else begin
         next_count = fallback[match_count];
         emit_count = held + EMIT_W'(1) - EMIT_W'(fallback[match_count]);
      end
   end

endmodule

// ----- rtl/core/streaming_find_replace_unit.sv -----
// Channel  Direction  Handshake                Payload
// req      in         req_tvalid / req_tready  tdata: text byte, tuser: command
// rsp      out        rsp_tvalid / rsp_tready  tdata: output byte, tlast: last of request
// csr      in         csr_valid / csr_ready    csr_index, csr_data (always ready)
//
// A request is decoded in the cycle it is accepted and its output bytes (0 to 8)
// land in one output buffer; the buffer drains one byte per cycle on rsp while rsp_tready is high.
// A new request is taken when the buffer is empty or its last byte leaves in
// that cycle, so one request per cycle while each yields at most one byte and
// rsp_tready stays high; a request that yields more holds off the next until its bytes have left.
// Synchronous reset clears the configuration, the partial match and the buffer.
module streaming_find_replace_unit #(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  sfr_pkg::byte_type         req_tdata,   // [7:0] text_byte
   input  logic                      req_tuser,   // [0] command
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output sfr_pkg::byte_type         rsp_tdata,   // [7:0] out_byte
   output logic                      rsp_tlast,   // run_last
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  sfr_pkg::reg_index_type    csr_index,
   input  logic [63:0]               csr_data
);
   import sfr_pkg::*;

   localparam int BUF_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
   localparam int COUNT_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int EMIT_W    = $clog2(BUF_BYTES + 1);

   // configuration
   logic [8*MAX_PATTERN-1:0]     pattern_ff;
   logic [3:0]                   pat_len_ff;
   logic [8*MAX_REPLACEMENT-1:0] replacement_ff;
   logic [3:0]                   rep_len_ff;

   // match state and output buffer
   logic [COUNT_W-1:0]     match_count_ff, match_count_in;
   logic [8*BUF_BYTES-1:0] out_buf_ff, out_buf_in;
   logic [EMIT_W-1:0]      out_cnt_ff, out_cnt_in;

   logic [8*BUF_BYTES-1:0] seq_bytes;
   logic [EMIT_W-1:0]      emit_count;
   logic [COUNT_W-1:0]     next_count;
   logic                   req_take;
   logic                   rsp_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         pat_len_ff     <= '0;
         replacement_ff <= '0;
         rep_len_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PATTERN_BYTES:      pattern_ff     <= csr_data[8*MAX_PATTERN-1:0];
            REG_PATTERN_LENGTH:     pat_len_ff     <= csr_data[3:0];
            REG_REPLACEMENT_BYTES:  replacement_ff <= csr_data[8*MAX_REPLACEMENT-1:0];
            REG_REPLACEMENT_LENGTH: rep_len_ff     <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   sfr_match #(
      .MAX_PATTERN     (MAX_PATTERN),
      .MAX_REPLACEMENT (MAX_REPLACEMENT)
   ) u_match (
      .pattern_bytes      (pattern_ff),
      .pattern_length     (pat_len_ff),
      .replacement_bytes  (replacement_ff),
      .replacement_length (rep_len_ff),
      .match_count        (match_count_ff),
      .command            (req_tuser),
      .text_byte          (req_tdata),
      .seq_bytes          (seq_bytes),
      .emit_count         (emit_count),
      .next_count         (next_count)
   );

   // Output side: byte 0 of the buffer is on the bus; tlast marks the final one.
   assign rsp_tvalid = (out_cnt_ff != '0);
   assign rsp_tdata  = out_buf_ff[7:0];
   assign rsp_tlast  = (out_cnt_ff == EMIT_W'(1));
   assign rsp_take   = rsp_tvalid && rsp_tready;

   // Take a request when the buffer is free by the end of this cycle.
   assign req_tready = (out_cnt_ff == '0) || (rsp_tlast && rsp_tready);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      match_count_in = match_count_ff;
      out_buf_in     = out_buf_ff;
      out_cnt_in     = out_cnt_ff;
      if (req_take) begin
         // load the bytes of the new request (a request with none leaves it empty)
         match_count_in = next_count;
         out_buf_in     = seq_bytes;
         out_cnt_in     = emit_count;
      end else if (rsp_take) begin
         // advance to the next byte
         out_buf_in = out_buf_ff >> 8;
         out_cnt_in = out_cnt_ff - EMIT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_count_ff <= '0;
         out_cnt_ff     <= '0;
      end else begin
         match_count_ff <= match_count_in;
         out_cnt_ff     <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_buf_ff <= out_buf_in;
   end

`ifndef SYNTH
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= EMIT_W'(BUF_BYTES))
      else $error("output buffer count beyond its depth");

   a_flush: assert property (@(posedge clock) disable iff (reset)
      req_take && ((req_tuser == CMD_END) || (req_tdata == NEWLINE))
      |=> match_count_ff == '0)
      else $error("partial match kept across a line end or end of input");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !req_take |=> out_cnt_ff == $past(out_cnt_ff) - EMIT_W'(1))
      else $error("output buffer did not advance by one byte");
`endif

endmodule

// ----- tb/sv/streaming_find_replace_unit_tb.sv -----
module streaming_find_replace_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfr_pkg::*;

   // cycles to let pass once the last expected byte is out, so that a request
   // that yields nothing has surely been decoded
   localparam int RSP_LATENCY     = 4;
   // one long receiver hold-off to back the block up into its request side
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SEGMENTS        = 12;
   localparam int SEGMENT_ITEMS   = 28;
   // marks a directed row whose output comes from the predictor
   localparam int FROM_PREDICTOR  = -1;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      reg_index_type idx;
      logic [63:0]   data;
      logic          cmd;
      byte_type      text;
      int            typed_n;      // number of typed output bytes, or FROM_PREDICTOR
      logic [63:0]   typed_bytes;  // typed output bytes, byte 0 lowest
   } stim_row_type;

   typedef struct packed {
      byte_type data;
      logic     last;
   } out_item_type;

   // DUT ports, all inputs known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   byte_type    req_tdata   = '0;
   logic        req_tuser   = CMD_TEXT;
   logic        rsp_tready  = 1'b0;
   logic        csr_valid   = 1'b0;
   reg_index_type csr_index = REG_PATTERN_BYTES;
   logic [63:0] csr_data    = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   byte_type    rsp_tdata;
   logic        rsp_tlast;
   logic        csr_ready;

   // predictor copy of the configuration and of the held partial match
   logic [63:0] pattern_reg         = '0;
   logic [3:0]  pattern_len_reg     = '0;
   logic [63:0] replacement_reg     = '0;
   logic [3:0]  replacement_len_reg = '0;
   logic [3:0]  held_count          = '0;
   byte_type    predicted_out [8];
   int          predicted_n;

   out_item_type expected_q [$];
   out_item_type exp_item;
   stim_row_type stim_rows [$];

   // hand-off from the sender to the monitor for typed directed rows
   int          typed_n     = FROM_PREDICTOR;
   logic [63:0] typed_bytes = '0;

   // shared pacing controls
   bit          no_idle          = 1'b0;
   bit          hold_off_request = 1'b0;
   int          error_count      = 0;

   streaming_find_replace_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] text_byte
      .req_tuser  (req_tuser),   // [0] command
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_byte
      .rsp_tlast  (rsp_tlast),   // run_last
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Work out the bytes one request yields and advance the held match.
   // Held bytes always come from the current pattern register.
   function automatic int predict_request(logic cmd, byte_type text);
      byte_type seq_buf [8];
      int       k;
      int       plen;
      int       rlen;
      int       j;
      int       n;
      bit       ok;
      k    = int'(held_count[2:0]);
      plen = (pattern_len_reg > 4'd8) ? 8 : int'(pattern_len_reg);
      rlen = (replacement_len_reg > 4'd8) ? 8 : int'(replacement_len_reg);
      for (int i = 0; i < k; i++) seq_buf[i] = pattern_reg[8*i +: 8];
      if (cmd == CMD_END) begin
         // flush whatever is held, possibly nothing
         held_count = '0;
         n = k;
      end else begin
         seq_buf[k] = text;
         if (k >= plen || text == NEWLINE) begin
            // pass through, stale count, or line end: dump held bytes and the new one
            held_count = '0;
            n = k + 1;
         end else if (text == pattern_reg[8*k +: 8]) begin
            if (k + 1 == plen) begin
               for (int i = 0; i < rlen; i++) seq_buf[i] = replacement_reg[8*i +: 8];
               held_count = '0;
               n = rlen;
            end else begin
               held_count = 4'(k + 1);
               n = 0;
            end
         end else begin
            // keep the longest tail that still is a pattern prefix, emit the rest
            for (j = k; j > 0; j--) begin
               ok = 1'b1;
               for (int i = 0; i < j; i++)
                  if (seq_buf[k + 1 - j + i] != pattern_reg[8*i +: 8]) ok = 1'b0;
               if (ok) break;
            end
            held_count = 4'(j);
            n = k + 1 - j;
         end
      end
      for (int i = 0; i < n; i++) predicted_out[i] = seq_buf[i];
      return n;
   endfunction

   function automatic void push_expected(byte_type d, logic l);
      out_item_type item;
      item.data = d;
      item.last = l;
      expected_q.push_back(item);
   endfunction

   function automatic stim_row_type csr_row(reg_index_type idx, logic [63:0] value);
      stim_row_type row;
      row.kind        = ROW_CSR;
      row.idx         = idx;
      row.data        = value;
      row.cmd         = CMD_TEXT;
      row.text        = '0;
      row.typed_n     = FROM_PREDICTOR;
      row.typed_bytes = '0;
      return row;
   endfunction

   function automatic stim_row_type text_row(logic cmd, byte_type text, int n,
                                             logic [63:0] bytes);
      stim_row_type row;
      row.kind        = ROW_REQ;
      row.idx         = REG_PATTERN_BYTES;
      row.data        = '0;
      row.cmd         = cmd;
      row.text        = text;
      row.typed_n     = n;
      row.typed_bytes = bytes;
      return row;
   endfunction

   // Monitor: track register writes, predict on each accepted request,
   // and check each accepted output byte against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PATTERN_BYTES:      pattern_reg         = csr_data;
               REG_PATTERN_LENGTH:     pattern_len_reg     = csr_data[3:0];
               REG_REPLACEMENT_BYTES:  replacement_reg     = csr_data;
               REG_REPLACEMENT_LENGTH: replacement_len_reg = csr_data[3:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predicted_n = predict_request(req_tuser, req_tdata);
            if (typed_n >= 0) begin
               // typed row: the predictor only advances its state
               for (int i = 0; i < typed_n; i++)
                  push_expected(typed_bytes[8*i +: 8], i == typed_n - 1);
            end else begin
               for (int i = 0; i < predicted_n; i++)
                  push_expected(predicted_out[i], i == predicted_n - 1);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               error_count++;
               $error("out_byte: expected none, actual %02h", rsp_tdata);
            end else begin
               exp_item = expected_q.pop_front();
               if (rsp_tdata !== exp_item.data) begin
                  error_count++;
                  $error("out_byte: expected %02h, actual %02h", exp_item.data, rsp_tdata);
               end
               if (rsp_tlast !== exp_item.last) begin
                  error_count++;
                  $error("run_last: expected %0b, actual %0b", exp_item.last, rsp_tlast);
               end
            end
         end
      end
   end

   // Offer one request after a random gap and hold it until accepted.
   // Entered and left at a falling edge.
   task automatic send_request(logic cmd, byte_type text, int n, logic [63:0] bytes);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_n     = n;
      typed_bytes = bytes;
      req_tvalid <= 1'b1;
      req_tdata  <= text;
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Write one register once every expected byte is out and the block is quiet.
   task automatic write_register(reg_index_type idx, logic [63:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
      repeat (RSP_LATENCY) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // One random phase: a fresh configuration, then text built mostly from
   // pattern prefixes so that partial matches, overlaps and full matches happen.
   task automatic run_segment(int seg);
      logic [63:0] pat;
      logic [63:0] rep;
      logic [63:0] len_word;
      int          plen;
      int          eplen;
      int          rlen;
      int          sent;
      int          r;
      int          run;
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
         pat = {$urandom(), $urandom()};
      end else begin
         for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 9))
               0:       pat[8*i +: 8] = NEWLINE;
               1:       pat[8*i +: 8] = 8'($urandom_range(0, 255));
               2, 3, 4: pat[8*i +: 8] = 8'h61;
               5, 6, 7: pat[8*i +: 8] = 8'h62;
               default: pat[8*i +: 8] = 8'h63;
            endcase
         end
      end
      rep = {$urandom(), $urandom()};
      // pin the extremes in phases 0, 1, 3 and 4, draw the rest
      case (seg)
         0:       begin plen = 8;  rlen = 8;  end
         1:       begin plen = 1;  rlen = 0;  end
         3:       begin plen = 0;  rlen = $urandom_range(0, 8); end
         4:       begin plen = 15; rlen = 15; end
         default: begin
            case ($urandom_range(0, 9))
               0:       plen = $urandom_range(9, 15);
               1:       plen = 0;
               default: plen = $urandom_range(1, 8);
            endcase
            rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
         end
      endcase
      eplen = (plen > 8) ? 8 : plen;
      write_register(REG_PATTERN_BYTES, pat);
      len_word      = {$urandom(), $urandom()};
      len_word[3:0] = 4'(plen);
      write_register(REG_PATTERN_LENGTH, len_word);
      write_register(REG_REPLACEMENT_BYTES, rep);
      len_word      = {$urandom(), $urandom()};
      len_word[3:0] = 4'(rlen);
      write_register(REG_REPLACEMENT_LENGTH, len_word);
      // back the block up once: receiver holds off while requests keep coming
      if (seg == 2) hold_off_request = 1'b1;
      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 45 && eplen > 0) begin
            run = $urandom_range(0, 1) ? eplen : $urandom_range(1, eplen);
            for (int i = 0; i < run; i++)
               send_request(CMD_TEXT, pat[8*i +: 8], FROM_PREDICTOR, '0);
            sent += run;
         end else begin
            if (r < 70)
               send_request(CMD_TEXT, pat[8*$urandom_range(0, 7) +: 8], FROM_PREDICTOR, '0);
            else if (r < 84)
               send_request(CMD_TEXT, 8'($urandom_range(0, 255)), FROM_PREDICTOR, '0);
            else if (r < 93)
               send_request(CMD_TEXT, NEWLINE, FROM_PREDICTOR, '0);
            else
               send_request(CMD_END, 8'($urandom_range(0, 255)), FROM_PREDICTOR, '0);
            sent++;
         end
      end
   endtask

   // Receiver: per output byte draw a stall, take the long hold-off once when asked.
   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_request) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Sender: reset, directed rows, random phases, then drain and report.
   initial begin
      // after reset: pattern length 0, text passes through
      stim_rows.push_back(text_row(CMD_TEXT, 8'h00, 1, 64'h00));
      stim_rows.push_back(text_row(CMD_TEXT, 8'hFF, 1, 64'hFF));
      stim_rows.push_back(text_row(CMD_END, 8'h5A, 0, 64'h0));
      // pattern "abc" replaced by "XY": full match, overlap on mismatch, flush on end
      stim_rows.push_back(csr_row(REG_PATTERN_BYTES, 64'h636261));
      stim_rows.push_back(csr_row(REG_PATTERN_LENGTH, 64'd3));
      stim_rows.push_back(csr_row(REG_REPLACEMENT_BYTES, 64'h5958));
      stim_rows.push_back(csr_row(REG_REPLACEMENT_LENGTH, 64'd2));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h61, 0, 64'h0));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h62, 0, 64'h0));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h63, 2, 64'h5958));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h61, FROM_PREDICTOR, 64'h0));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h61, FROM_PREDICTOR, 64'h0));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h62, FROM_PREDICTOR, 64'h0));
      stim_rows.push_back(text_row(CMD_END, 8'hA5, FROM_PREDICTOR, 64'h0));
      // empty replacement deletes the match
      stim_rows.push_back(csr_row(REG_REPLACEMENT_LENGTH, 64'd0));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h61, 0, 64'h0));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h62, 0, 64'h0));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h63, 0, 64'h0));
      // oversized lengths clamp to eight: seven held, shift by one, then eight out
      stim_rows.push_back(csr_row(REG_PATTERN_BYTES, 64'h6261616161616161));
      stim_rows.push_back(csr_row(REG_PATTERN_LENGTH, 64'hF));
      stim_rows.push_back(csr_row(REG_REPLACEMENT_BYTES, 64'h0123456789ABCDEF));
      stim_rows.push_back(csr_row(REG_REPLACEMENT_LENGTH, 64'hF));
      for (int i = 0; i < 8; i++)
         stim_rows.push_back(text_row(CMD_TEXT, 8'h61, FROM_PREDICTOR, 64'h0));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h62, 8, 64'h0123456789ABCDEF));
      // hold three, then shorten and change the pattern: stale count dumps held bytes
      for (int i = 0; i < 3; i++)
         stim_rows.push_back(text_row(CMD_TEXT, 8'h61, FROM_PREDICTOR, 64'h0));
      stim_rows.push_back(csr_row(REG_PATTERN_BYTES, 64'h0A61));
      stim_rows.push_back(csr_row(REG_PATTERN_LENGTH, 64'd2));
      stim_rows.push_back(text_row(CMD_TEXT, 8'h7A, FROM_PREDICTOR, 64'h0));
      // pattern holding a line end never matches; line end flushes the held byte
      stim_rows.push_back(text_row(CMD_TEXT, 8'h61, FROM_PREDICTOR, 64'h0));
      stim_rows.push_back(text_row(CMD_TEXT, NEWLINE, FROM_PREDICTOR, 64'h0));

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR)
            write_register(stim_rows[i].idx, stim_rows[i].data);
         else
            send_request(stim_rows[i].cmd, stim_rows[i].text,
                         stim_rows[i].typed_n, stim_rows[i].typed_bytes);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) run_segment(seg);

      // drop valid, drain, then give stray output a chance to show up
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY * 4) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
